// File: src/rqu_pkg.sv
// retransmission queue package: codes, command and status types
// no dependencies
package rqu_pkg;

  localparam int QueueDepthDef = 16;

  localparam logic [2:0] REQ_PUSH  = 3'd0;
  localparam logic [2:0] REQ_ACK   = 3'd1;
  localparam logic [2:0] REQ_NACK  = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_FLUSH = 3'd4;

  localparam logic [1:0] KIND_RESEND = 2'd0;
  localparam logic [1:0] KIND_DROP   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [15:0] TimeoutRst = 16'd100;
  localparam logic [7:0]  RetriesRst = 8'd3;

  localparam logic ADDR_TIMEOUT = 1'b0;
  localparam logic ADDR_RETRIES = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_FIND,
    CMD_INSERT,
    CMD_SCAN,
    CMD_EMIT,
    CMD_COMPACT,
    CMD_DONE
  } cmd_e;

  typedef struct packed {
    logic go_find;
    logic go_scan;
    logic find_stop;
    logic insert_ok;
    logic scan_end;
    logic walk_end;
    logic out_free;
  } dp_stat_t;

endpackage

// File: src/rqu_ctrl.sv
// retransmission queue controller state machine
// depends on rqu_pkg
module rqu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rqu_pkg::dp_stat_t stat_i,
  output rqu_pkg::cmd_e     cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FIND    = 3'd1;
  localparam logic [2:0] S_INSERT  = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_COMPACT = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = rqu_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = rqu_pkg::CMD_START;
          if (stat_i.go_find) state_d = S_FIND;
          else if (stat_i.go_scan) state_d = S_SCAN;
          else state_d = S_DONE;
        end
      end
      S_FIND: begin
        cmd_o = rqu_pkg::CMD_FIND;
        if (stat_i.find_stop) state_d = stat_i.insert_ok ? S_INSERT : S_DONE;
      end
      S_INSERT: begin
        cmd_o   = rqu_pkg::CMD_INSERT;
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o = rqu_pkg::CMD_SCAN;
        if (stat_i.scan_end) state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o = rqu_pkg::CMD_EMIT;
        if (stat_i.walk_end) state_d = S_COMPACT;
      end
      S_COMPACT: begin
        cmd_o = rqu_pkg::CMD_COMPACT;
        if (stat_i.walk_end) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o = rqu_pkg::CMD_DONE;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/rqu_datapath.sv
// retransmission queue datapath: sorted entry table, walk index, timer, output word
// depends on rqu_pkg
module rqu_datapath #(
  parameter int QueueDepth = rqu_pkg::QueueDepthDef,
  parameter int IW = $clog2(QueueDepth),
  parameter int CW = $clog2(QueueDepth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rqu_pkg::cmd_e     cmd_i,
  output rqu_pkg::dp_stat_t stat_o,
  input  logic [15:0]       timeout_i,
  input  logic [7:0]        max_retries_i,
  input  logic [2:0]        req_type_i,
  input  logic [31:0]       seq_num_i,
  input  logic [15:0]       pdu_handle_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [31:0]       entry_seq_o,
  output logic [15:0]       entry_handle_o,
  output logic [1:0]        status_o,
  output logic [CW-1:0]     occupancy_o,
  output logic              last_o
);

  logic [31:0] seqs_q    [QueueDepth];
  logic [15:0] handles_q [QueueDepth];
  logic [31:0] stamps_q  [QueueDepth];
  logic [7:0]  retries_q [QueueDepth];
  logic [QueueDepth-1:0] sel_q, drop_q;

  logic [2:0]    req_q;
  logic [31:0]   seq_q;
  logic [15:0]   handle_q;
  logic [1:0]    status_q;
  logic [CW-1:0] cnt_q, drops_q, pos_q;
  logic          dir_q;
  logic [31:0]   now_q, deadline_q;
  logic          running_q;
  logic          out_valid_q;

  logic [CW-1:0] epos, pos_step;
  logic [IW-1:0] eidx;
  logic [31:0]   cur_seq, cur_stamp, age;
  logic [15:0]   cur_handle;
  logic [7:0]    cur_ret, ret_inc;
  logic          walk_end, is_ack, is_nack, is_tick, full, dup, old;
  logic          retry_drop, scan_end, scan_retry, out_free, emit_load, done_load;
  logic          tick_hit;

  assign epos       = dir_q ? pos_q - CW'(1) : pos_q;
  assign eidx       = epos[IW-1:0];
  assign pos_step   = dir_q ? pos_q - CW'(1) : pos_q + CW'(1);
  assign walk_end   = dir_q ? (pos_q == '0) : (pos_q == cnt_q);
  assign cur_seq    = seqs_q[eidx];
  assign cur_handle = handles_q[eidx];
  assign cur_stamp  = stamps_q[eidx];
  assign cur_ret    = retries_q[eidx];

  assign is_ack  = (req_q == rqu_pkg::REQ_ACK);
  assign is_nack = (req_q == rqu_pkg::REQ_NACK);
  assign is_tick = (req_q == rqu_pkg::REQ_TICK);
  assign full    = (cnt_q == CW'(QueueDepth));
  assign dup     = !walk_end && (cur_seq == seq_q);

  assign ret_inc    = (cur_ret == 8'hFF) ? cur_ret : cur_ret + 8'd1;
  assign retry_drop = (ret_inc >= max_retries_i);
  assign age        = now_q - cur_stamp - {16'd0, timeout_i};
  assign old        = !age[31];
  assign scan_end   = walk_end || (is_nack && (cur_seq < seq_q));
  assign scan_retry = !scan_end && (is_nack || (is_tick && old));

  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_load = (cmd_i == rqu_pkg::CMD_EMIT) && !walk_end && sel_q[eidx] && out_free;
  assign done_load = (cmd_i == rqu_pkg::CMD_DONE) && out_free;
  assign tick_hit  = running_q && ((now_q + 32'd1) == deadline_q);

  always_comb begin
    stat_o.go_find   = (req_type_i == rqu_pkg::REQ_PUSH);
    stat_o.go_scan   = (req_type_i == rqu_pkg::REQ_ACK) || (req_type_i == rqu_pkg::REQ_NACK) ||
                       ((req_type_i == rqu_pkg::REQ_TICK) && tick_hit);
    stat_o.find_stop = walk_end || (cur_seq >= seq_q);
    stat_o.insert_ok = !dup && !full;
    stat_o.scan_end  = scan_end;
    stat_o.walk_end  = walk_end;
    stat_o.out_free  = out_free;
  end

  // entry table, shifted in place for insert and removal
  for (genvar g = 0; g < QueueDepth; g++) begin : g_entry
    localparam int Prev = (g == 0) ? 0 : g - 1;
    localparam int Next = (g == QueueDepth - 1) ? g : g + 1;
    always_ff @(posedge clk_i) begin
      case (cmd_i)
        rqu_pkg::CMD_INSERT: begin
          if (CW'(g) > pos_q) begin
            seqs_q[g]    <= seqs_q[Prev];
            handles_q[g] <= handles_q[Prev];
            stamps_q[g]  <= stamps_q[Prev];
            retries_q[g] <= retries_q[Prev];
          end else if (CW'(g) == pos_q) begin
            seqs_q[g]    <= seq_q;
            handles_q[g] <= handle_q;
            stamps_q[g]  <= now_q;
            retries_q[g] <= 8'd0;
          end
        end
        rqu_pkg::CMD_SCAN: begin
          if (scan_retry && (eidx == IW'(g))) retries_q[g] <= ret_inc;
        end
        rqu_pkg::CMD_COMPACT: begin
          if (!walk_end && drop_q[eidx] && (IW'(g) >= eidx) && (g < QueueDepth - 1)) begin
            seqs_q[g]    <= seqs_q[Next];
            handles_q[g] <= handles_q[Next];
            stamps_q[g]  <= stamps_q[Next];
            retries_q[g] <= retries_q[Next];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == rqu_pkg::CMD_START) begin
      req_q    <= req_type_i;
      seq_q    <= seq_num_i;
      handle_q <= pdu_handle_i;
    end
    if (emit_load) begin
      kind_o         <= drop_q[eidx] ? rqu_pkg::KIND_DROP : rqu_pkg::KIND_RESEND;
      entry_seq_o    <= cur_seq;
      entry_handle_o <= cur_handle;
      status_o       <= rqu_pkg::ST_OK;
      occupancy_o    <= cnt_q - drops_q;
      last_o         <= 1'b0;
    end else if (done_load) begin
      kind_o         <= rqu_pkg::KIND_DONE;
      entry_seq_o    <= '0;
      entry_handle_o <= '0;
      status_o       <= status_q;
      occupancy_o    <= cnt_q;
      last_o         <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= rqu_pkg::ST_OK;
      cnt_q       <= '0;
      drops_q     <= '0;
      pos_q       <= '0;
      dir_q       <= 1'b0;
      now_q       <= '0;
      deadline_q  <= '0;
      running_q   <= 1'b0;
      sel_q       <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_load || done_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i)
        rqu_pkg::CMD_START: begin
          status_q <= rqu_pkg::ST_OK;
          drops_q  <= '0;
          sel_q    <= '0;
          drop_q   <= '0;
          if (req_type_i == rqu_pkg::REQ_NACK) begin
            pos_q <= cnt_q;
            dir_q <= 1'b1;
          end else begin
            pos_q <= '0;
            dir_q <= 1'b0;
          end
          if (req_type_i == rqu_pkg::REQ_TICK) now_q <= now_q + 32'd1;
          if ((req_type_i == rqu_pkg::REQ_PUSH) && !running_q) begin
            deadline_q <= now_q + {16'd0, timeout_i};
            running_q  <= 1'b1;
          end
          if (req_type_i == rqu_pkg::REQ_FLUSH) begin
            cnt_q     <= '0;
            running_q <= 1'b0;
          end
        end
        rqu_pkg::CMD_FIND: begin
          if (walk_end || (cur_seq >= seq_q)) begin
            if (dup) status_q <= rqu_pkg::ST_DUP;
            else if (full) status_q <= rqu_pkg::ST_FULL;
          end else begin
            pos_q <= pos_step;
          end
        end
        rqu_pkg::CMD_INSERT: cnt_q <= cnt_q + CW'(1);
        rqu_pkg::CMD_SCAN: begin
          if (scan_end) begin
            pos_q <= is_nack ? cnt_q : '0;
            dir_q <= is_nack;
          end else begin
            pos_q <= pos_step;
            if (is_ack && (cur_seq <= seq_q)) begin
              drop_q[eidx] <= 1'b1;
              drops_q      <= drops_q + CW'(1);
            end
            if (scan_retry) begin
              sel_q[eidx] <= 1'b1;
              if (retry_drop) begin
                drop_q[eidx] <= 1'b1;
                drops_q      <= drops_q + CW'(1);
              end
            end
          end
        end
        rqu_pkg::CMD_EMIT: begin
          if (walk_end) begin
            pos_q <= cnt_q;
            dir_q <= 1'b1;
          end else if (!sel_q[eidx] || out_free) begin
            pos_q <= pos_step;
          end
        end
        rqu_pkg::CMD_COMPACT: begin
          if (walk_end) begin
            if (is_tick && (cnt_q == '0)) begin
              running_q <= 1'b0;
            end else begin
              deadline_q <= now_q + {16'd0, timeout_i};
              running_q  <= 1'b1;
            end
          end else begin
            pos_q <= pos_step;
            if (drop_q[eidx]) cnt_q <= cnt_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/retransmission_queue_unit.sv
// retransmission queue top level: configuration registers, controller and datapath
// depends on rqu_pkg, rqu_ctrl, rqu_datapath
// One request word is taken at a time; the block is busy until its done word is
// loaded. A push walks the sorted table to its slot. An
// ack, a nack or an expiring tick makes three walks over the held entries (scan and
// retry update, result emission, removal by shifting), and the emission walk waits
// whenever the output side stalls. Other requests go straight to the done word.
// Every resend or drop word is followed by a done word with last set.
module retransmission_queue_unit #(
  parameter int QueueDepth = rqu_pkg::QueueDepthDef,
  parameter int CW = $clog2(QueueDepth + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    req_type_i,
  input  logic [31:0]   seq_num_i,
  input  logic [15:0]   pdu_handle_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [31:0]   entry_seq_o,
  output logic [15:0]   entry_handle_o,
  output logic [1:0]    status_o,
  output logic [CW-1:0] occupancy_o,
  output logic          last_o
);

  logic [15:0] timeout_q;
  logic [7:0]  max_retries_q;
  rqu_pkg::cmd_e     cmd;
  rqu_pkg::dp_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= rqu_pkg::TimeoutRst;
      max_retries_q <= rqu_pkg::RetriesRst;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == rqu_pkg::ADDR_TIMEOUT) timeout_q <= pwdata[15:0];
      else max_retries_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rqu_pkg::ADDR_RETRIES) prdata = {24'd0, max_retries_q};
    else prdata = {16'd0, timeout_q};
  end

  rqu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rqu_datapath #(
    .QueueDepth (QueueDepth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .timeout_i      (timeout_q),
    .max_retries_i  (max_retries_q),
    .req_type_i     (req_type_i),
    .seq_num_i      (seq_num_i),
    .pdu_handle_i   (pdu_handle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .entry_seq_o    (entry_seq_o),
    .entry_handle_o (entry_handle_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .last_o         (last_o)
  );

endmodule
